// File: rtl/kraw_pkg.sv
// shared types, constants and the control program of the retention window
// no dependencies; imported by keyframe_aligned_retention_window and kraw_checker
`default_nettype none

package kraw_pkg;

    localparam int unsigned DEF_MAX_UNITS = 256;
    localparam int unsigned DEF_SIZE_BITS = 24;

    localparam int unsigned BUDGET_W = 30;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned BYTES_W  = 32;
    localparam int unsigned TOT_W    = 33;   // total may pass 32 bits before trimming
    localparam int unsigned CFG_W    = 32;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = BUDGET_W'(67108864);
    localparam logic [TICK_W-1:0]   WINDOW_RST = TICK_W'(30000);

    // configuration register indexes
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    // result status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_DROPPED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [3:0] t_pc;

    // program steps
    localparam t_pc PC_IDLE      = 4'd0;
    localparam t_pc PC_CHK_DROP  = 4'd1;
    localparam t_pc PC_CHK_FULL  = 4'd2;
    localparam t_pc PC_APPEND    = 4'd3;
    localparam t_pc PC_TRIM_INIT = 4'd4;
    localparam t_pc PC_FRONT_RD  = 4'd5;
    localparam t_pc PC_TRIM_TEST = 4'd6;
    localparam t_pc PC_SCAN_END  = 4'd7;
    localparam t_pc PC_SCAN_KEY  = 4'd8;
    localparam t_pc PC_KEY_CHK   = 4'd9;
    localparam t_pc PC_EVICT     = 4'd10;
    localparam t_pc PC_FINAL     = 4'd11;
    localparam t_pc PC_CLEAR     = 4'd12;
    localparam t_pc PC_OUT_OK    = 4'd13;
    localparam t_pc PC_OUT_DROP  = 4'd14;
    localparam t_pc PC_OUT_FULL  = 4'd15;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_START,
        C_DROP,
        C_FULL,
        C_NO_TRIM,
        C_POS_END,
        C_RD_KEY,
        C_STOP,
        C_OVER2
    } t_cond;

    typedef enum logic [3:0] {
        A_NONE,
        A_LATCH,
        A_APPEND,
        A_INIT,
        A_FRONT,
        A_SCAN,
        A_EVICT,
        A_CLEAR,
        A_OUT_OK,
        A_OUT_DROP,
        A_OUT_FULL
    } t_act;

    typedef struct packed {
        t_cond cond;
        t_act  act;
        t_pc   jt;    // next step when the condition holds
        t_pc   jf;    // next step otherwise
    } t_ctrl;

    function automatic t_ctrl kraw_rom(input t_pc pc);
        t_ctrl w;
        w = '{cond: C_ALWAYS, act: A_NONE, jt: PC_IDLE, jf: PC_IDLE};
        case (pc)
            PC_IDLE:      w = '{C_START,   A_LATCH,    PC_CHK_DROP,  PC_IDLE};
            PC_CHK_DROP:  w = '{C_DROP,    A_NONE,     PC_OUT_DROP,  PC_CHK_FULL};
            PC_CHK_FULL:  w = '{C_FULL,    A_NONE,     PC_OUT_FULL,  PC_APPEND};
            PC_APPEND:    w = '{C_ALWAYS,  A_APPEND,   PC_TRIM_INIT, PC_TRIM_INIT};
            PC_TRIM_INIT: w = '{C_ALWAYS,  A_INIT,     PC_FRONT_RD,  PC_FRONT_RD};
            PC_FRONT_RD:  w = '{C_ALWAYS,  A_NONE,     PC_TRIM_TEST, PC_TRIM_TEST};
            PC_TRIM_TEST: w = '{C_NO_TRIM, A_FRONT,    PC_FINAL,     PC_SCAN_END};
            PC_SCAN_END:  w = '{C_POS_END, A_NONE,     PC_FINAL,     PC_SCAN_KEY};
            PC_SCAN_KEY:  w = '{C_RD_KEY,  A_SCAN,     PC_KEY_CHK,   PC_SCAN_END};
            PC_KEY_CHK:   w = '{C_STOP,    A_NONE,     PC_FINAL,     PC_EVICT};
            PC_EVICT:     w = '{C_ALWAYS,  A_EVICT,    PC_TRIM_INIT, PC_TRIM_INIT};
            PC_FINAL:     w = '{C_OVER2,   A_NONE,     PC_CLEAR,     PC_OUT_OK};
            PC_CLEAR:     w = '{C_ALWAYS,  A_CLEAR,    PC_OUT_OK,    PC_OUT_OK};
            PC_OUT_OK:    w = '{C_ALWAYS,  A_OUT_OK,   PC_IDLE,      PC_IDLE};
            PC_OUT_DROP:  w = '{C_ALWAYS,  A_OUT_DROP, PC_IDLE,      PC_IDLE};
            PC_OUT_FULL:  w = '{C_ALWAYS,  A_OUT_FULL, PC_IDLE,      PC_IDLE};
            default:      w = '{C_ALWAYS,  A_NONE,     PC_IDLE,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/keyframe_aligned_retention_window.sv
// keyframe aligned retention window: ring of coded-unit sizes and times,
// trimmed in whole keyframe intervals, or cleared, by a microcoded sequencer
// depends on kraw_pkg
//
// usage
//   request channel: drive i_unit_size, i_is_keyframe and i_now_tick with start
//   high; the request is taken at a rising edge where start is high and busy is
//   low. busy stays high until the cycle in which o_done is high.
//   result channel: o_done is high for exactly one cycle with o_status,
//   o_evicted_units, o_cleared, o_held_units and o_held_bytes; the receiver
//   cannot stall, so it must take the result in that cycle. one result per
//   request, in request order. a new request may be taken in the o_done cycle.
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 byte budget, 1 keep window) at the clock edge; write only while idle.
// request flow, one request at a time from acceptance until its result is taken
//   dropped request: drop check, then result; request rejected by a full ring:
//   drop check, full check, then result
//   stored request: append, trim setup, front read, trim test, final check,
//   a clear step when the store is cleared, then result; each trim pass that
//   evicts scans for the next keyframe, checks it and evicts ahead of it; the
//   last pass stops at the trim test, the keyframe check or the end-of-ring test
// reset (synchronous, active low) empties the ring, returns the budget and
// window to their defaults and idles the sequencer; the ring contents are
// not cleared since only held entries are ever read
`default_nettype none

module keyframe_aligned_retention_window #(
    parameter int unsigned MAX_UNITS = kraw_pkg::DEF_MAX_UNITS,
    parameter int unsigned SIZE_BITS = kraw_pkg::DEF_SIZE_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [SIZE_BITS-1:0]             i_unit_size,
    input  wire logic                             i_is_keyframe,
    input  wire logic [kraw_pkg::TICK_W-1:0]      i_now_tick,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [kraw_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                                  o_done,
    output logic [1:0]                            o_status,
    output logic [$clog2(MAX_UNITS+1)-1:0]        o_evicted_units,
    output logic                                  o_cleared,
    output logic [$clog2(MAX_UNITS+1)-1:0]        o_held_units,
    output logic [kraw_pkg::BYTES_W-1:0]          o_held_bytes
);
    import kraw_pkg::*;

    localparam int unsigned IDX_W  = $clog2(MAX_UNITS);
    localparam int unsigned CNT_W  = $clog2(MAX_UNITS+1);
    localparam int unsigned SUM_W  = CNT_W + 1;
    localparam int unsigned WORD_W = SIZE_BITS + 1 + TICK_W;
    localparam logic [SUM_W-1:0] MAX_S = SUM_W'(MAX_UNITS);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_UNITS);

    // sequencer
    t_pc   r_pc, n_pc;
    t_ctrl ctrl;
    logic  cond_hit;

    // configuration
    logic [BUDGET_W-1:0] r_budget;
    logic [TICK_W-1:0]   r_window;

    // ring bookkeeping
    logic [IDX_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [TOT_W-1:0] r_total,  n_total;

    // latched request and scan datapath
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic                 r_key,  n_key;
    logic [TICK_W-1:0]    r_now,  n_now;
    logic [CNT_W-1:0]     r_pos,  n_pos;
    logic [TOT_W-1:0]     r_acc,  n_acc;
    logic [CNT_W-1:0]     r_evict, n_evict;
    logic                 r_clr,  n_clr;

    // result registers
    logic                 r_done, n_done;
    logic [1:0]           r_status, n_status;
    logic [CNT_W-1:0]     r_o_evict, n_o_evict;
    logic                 r_o_clr, n_o_clr;
    logic [CNT_W-1:0]     r_o_held, n_o_held;
    logic [BYTES_W-1:0]   r_o_bytes, n_o_bytes;

    // ring memory: {keyframe, time, size}
    logic [WORD_W-1:0] r_mem [MAX_UNITS];
    logic [WORD_W-1:0] r_rd;
    logic              mem_we;

    logic [SUM_W-1:0]     rd_sum, wr_sum;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 rd_key;
    logic [TICK_W-1:0]    rd_time;
    logic [TICK_W-1:0]    rd_age;
    logic                 over_budget;

    // ring slot of scan position and of the append position, wrapped once
    always_comb begin
        rd_sum = SUM_W'(r_oldest) + SUM_W'(r_pos);
        if (rd_sum >= MAX_S) begin
            rd_sum = rd_sum - MAX_S;
        end
        wr_sum = SUM_W'(r_oldest) + SUM_W'(r_count);
        if (wr_sum >= MAX_S) begin
            wr_sum = wr_sum - MAX_S;
        end
    end

    assign rd_addr = rd_sum[IDX_W-1:0];
    assign wr_addr = wr_sum[IDX_W-1:0];

    assign rd_size = r_rd[SIZE_BITS-1:0];
    assign rd_time = r_rd[SIZE_BITS +: TICK_W];
    assign rd_key  = r_rd[WORD_W-1];
    // modular age of the entry in the read register
    assign rd_age  = r_now - rd_time;
    assign over_budget = r_total > TOT_W'(r_budget);

    // control word of the current step
    assign ctrl = kraw_rom(r_pc);

    // jump condition
    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:  cond_hit = 1'b1;
            C_START:   cond_hit = start;
            C_DROP:    cond_hit = (r_count == '0) && !r_key;
            C_FULL:    cond_hit = r_count >= MAX_C;
            C_NO_TRIM: cond_hit = !((r_count > CNT_W'(1)) &&
                                    (over_budget || (rd_age > r_window)));
            C_POS_END: cond_hit = r_pos >= r_count;
            C_RD_KEY:  cond_hit = rd_key;
            C_STOP:    cond_hit = !over_budget && (rd_age < r_window);
            C_OVER2:   cond_hit = r_total > TOT_W'({r_budget, 1'b0});
            default:   cond_hit = 1'b0;
        endcase
    end

    assign n_pc = cond_hit ? ctrl.jt : ctrl.jf;

    // datapath actions
    always_comb begin
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_total   = r_total;
        n_size    = r_size;
        n_key     = r_key;
        n_now     = r_now;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_evict   = r_evict;
        n_clr     = r_clr;
        n_done    = 1'b0;
        n_status  = r_status;
        n_o_evict = r_o_evict;
        n_o_clr   = r_o_clr;
        n_o_held  = r_o_held;
        n_o_bytes = r_o_bytes;
        mem_we    = 1'b0;
        case (ctrl.act)
            A_NONE: begin
            end
            A_LATCH: begin
                n_size  = i_unit_size;
                n_key   = i_is_keyframe;
                n_now   = i_now_tick;
                n_evict = '0;
                n_clr   = 1'b0;
            end
            A_APPEND: begin
                mem_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_total = r_total + TOT_W'(r_size);
            end
            A_INIT: begin
                n_pos = '0;
            end
            A_FRONT: begin
                // front entry is counted before the keyframe search
                n_acc = TOT_W'(rd_size);
                n_pos = CNT_W'(1);
            end
            A_SCAN: begin
                if (!cond_hit) begin
                    n_acc = r_acc + TOT_W'(rd_size);
                    n_pos = r_pos + CNT_W'(1);
                end
            end
            A_EVICT: begin
                // drop everything ahead of the keyframe at r_pos
                n_total  = r_total - r_acc;
                n_oldest = rd_addr;
                n_count  = r_count - r_pos;
                n_evict  = r_evict + r_pos;
            end
            A_CLEAR: begin
                n_evict  = r_evict + r_count;
                n_count  = '0;
                n_total  = '0;
                n_oldest = '0;
                n_clr    = 1'b1;
            end
            A_OUT_OK: begin
                n_done    = 1'b1;
                n_status  = ST_STORED;
                n_o_evict = r_evict;
                n_o_clr   = r_clr;
                n_o_held  = r_count;
                n_o_bytes = r_total[BYTES_W-1:0];
            end
            A_OUT_DROP: begin
                n_done    = 1'b1;
                n_status  = ST_DROPPED;
                n_o_evict = '0;
                n_o_clr   = 1'b0;
                n_o_held  = r_count;
                n_o_bytes = r_total[BYTES_W-1:0];
            end
            A_OUT_FULL: begin
                n_done    = 1'b1;
                n_status  = ST_FULL;
                n_o_evict = '0;
                n_o_clr   = 1'b0;
                n_o_held  = r_count;
                n_o_bytes = r_total[BYTES_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
            r_total  <= '0;
            r_done   <= 1'b0;
            r_budget <= BUDGET_RST;
            r_window <= WINDOW_RST;
        end else begin
            r_pc     <= n_pc;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_total  <= n_total;
            r_done   <= n_done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BUDGET: r_budget <= i_cfg_data[BUDGET_W-1:0];
                    CFG_WINDOW: r_window <= i_cfg_data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_size    <= n_size;
        r_key     <= n_key;
        r_now     <= n_now;
        r_pos     <= n_pos;
        r_acc     <= n_acc;
        r_evict   <= n_evict;
        r_clr     <= n_clr;
        r_status  <= n_status;
        r_o_evict <= n_o_evict;
        r_o_clr   <= n_o_clr;
        r_o_held  <= n_o_held;
        r_o_bytes <= n_o_bytes;
    end

    // ring memory, at most one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= {r_key, r_now, r_size};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign busy            = (r_pc != PC_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_evicted_units = r_o_evict;
    assign o_cleared       = r_o_clr;
    assign o_held_units    = r_o_held;
    assign o_held_bytes    = r_o_bytes;

endmodule

`default_nettype wire

// File: rtl/kraw_checker.sv
// port-level checks for the retention window, with the bind that attaches them
// depends on kraw_pkg and keyframe_aligned_retention_window
`default_nettype none

module kraw_checker #(
    parameter int unsigned MAX_UNITS = kraw_pkg::DEF_MAX_UNITS
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              o_done,
    input wire logic [1:0]                        o_status,
    input wire logic [$clog2(MAX_UNITS+1)-1:0]    o_evicted_units,
    input wire logic                              o_cleared,
    input wire logic [$clog2(MAX_UNITS+1)-1:0]    o_held_units,
    input wire logic [kraw_pkg::BYTES_W-1:0]      o_held_bytes
);
    import kraw_pkg::*;

    // a taken request keeps the block busy in the next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // every result follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without preceding work");

    // a dropped or rejected unit removes nothing
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_STORED) |-> (o_evicted_units == '0 && !o_cleared))
        else $error("rejected unit changed the store");

    // a clear leaves the store empty
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_cleared) |-> (o_held_units == '0 && o_held_bytes == '0))
        else $error("store not empty after clear");

    // a stored unit stays held unless the store was cleared
    a_store_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_STORED) |-> (o_held_units != '0 || o_cleared))
        else $error("stored unit missing");

endmodule

bind keyframe_aligned_retention_window kraw_checker #(
    .MAX_UNITS(MAX_UNITS)
) u_kraw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_evicted_units (o_evicted_units),
    .o_cleared       (o_cleared),
    .o_held_units    (o_held_units),
    .o_held_bytes    (o_held_bytes)
);

`default_nettype wire
